/* hw/rtl/dimctl_pkg.sv */
package dimctl_pkg;

    // Default values for the top-level parameters.
    localparam int CHANNELS_DEF  = 4;
    localparam int LEVEL_MAX_DEF = 1000;

    // Widths fixed by the payload fields.
    localparam int LEVEL_W = 16;
    localparam int FADE_W  = 16;
    localparam int PCT_W   = 7;
    localparam int TIME_W  = 32;
    localparam int CH_W    = 3;
    localparam int FUNC_W  = 2;
    localparam int CFG_W   = 64;
    localparam int CFG_A_W = 2;
    localparam int SEC_W   = 16;
    localparam int MAX_CHANNELS = 4;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_MANUAL_FADE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MANUAL_PROF   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_AUTO_LEVEL    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SET_ROCKER    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_A_W-1:0] REG_SUPPRESS_SECS = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_FADE_ON       = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_FADE_OFF      = 2'd2;

    // Percent setpoint of a fully lit channel.
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    // One channel's stored state, held as a single memory word.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [PCT_W-1:0]   percent;
        logic               auto_on;
        logic               rocker_min;
        logic [LEVEL_W-1:0] last_level;
        logic               has_last;
        logic [TIME_W-1:0]  suppress_until;
    } chan_state_t;

    // State of a channel that has not been written since reset.
    localparam chan_state_t CHAN_RESET = '{
        level:          '0,
        percent:        PCT_FULL,
        auto_on:        1'b0,
        rocker_min:     1'b0,
        last_level:     '0,
        has_last:       1'b0,
        suppress_until: '0
    };

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctl_state_t;

    // Control strobes from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic ram_rd;
        logic commit;
    } ctl_strobe_t;

endpackage

/* hw/rtl/dimmer_channel_manual_auto_control.sv */
// Channel   | Direction | Handshake         | Beat contents
// ----------+-----------+-------------------+--------------------------------------------
// s_        | in        | s_valid / s_ready | func, channel, level, fade_ms, flag, now_ms
// m_        | out       | m_valid / m_ready | drive command, accepted flag, channel status
// cfg_      | in        | cfg_wr_en         | register index and write data, no wait
//
// Each beat has a read step, which reads the channel's word from the state memory,
// and a compute step, which computes, writes it back and loads the output register.
// A new input beat is taken while the previous result still waits in the output
// register; the compute cycle holds until that register is free.
// Reset clears the per-channel valid bits, so an unwritten channel reads as its reset state.

module dimmer_channel_manual_auto_control #(
    parameter int CHANNELS  = dimctl_pkg::CHANNELS_DEF,
    parameter int LEVEL_MAX = dimctl_pkg::LEVEL_MAX_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [dimctl_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [dimctl_pkg::CFG_W-1:0]       cfg_wr_data,
    // Input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [dimctl_pkg::FUNC_W-1:0]      s_func,
    input  logic [dimctl_pkg::CH_W-1:0]        s_channel,
    input  logic [dimctl_pkg::LEVEL_W-1:0]     s_level,
    input  logic [dimctl_pkg::FADE_W-1:0]      s_fade_ms,
    input  logic                               s_flag_value,
    input  logic [dimctl_pkg::TIME_W-1:0]      s_now_ms,
    // Result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_drive_valid,
    output logic [dimctl_pkg::LEVEL_W-1:0]     m_drive_level,
    output logic [dimctl_pkg::FADE_W-1:0]      m_drive_fade_ms,
    output logic                               m_accepted,
    output logic [dimctl_pkg::LEVEL_W-1:0]     m_level_now,
    output logic [dimctl_pkg::PCT_W-1:0]       m_percent_now,
    output logic                               m_auto_now
);

    import dimctl_pkg::*;

    localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STATE_W  = $bits(chan_state_t);
    // Exact division by LEVEL_MAX through a rounded-up reciprocal.
    localparam int NUM_MAX  = 100 * LEVEL_MAX + LEVEL_MAX / 2;
    localparam int NUM_W    = $clog2(NUM_MAX + 1);
    localparam int DIV_L    = $clog2(LEVEL_MAX);
    localparam int SHIFT    = NUM_W + DIV_L;
    localparam int PROD_W   = SHIFT + PCT_W + 1;
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(LEVEL_MAX) - 64'd1) / 64'(LEVEL_MAX);
    localparam logic [LEVEL_W-1:0] LVL_MAX_C  = LEVEL_W'(LEVEL_MAX);
    localparam logic [NUM_W-1:0]   HALF_MAX_C = NUM_W'(LEVEL_MAX / 2);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SEC_W-1:0] suppress_secs_reg;
    logic [CFG_W-1:0] fade_on_reg;
    logic [CFG_W-1:0] fade_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            suppress_secs_reg <= '0;
            fade_on_reg       <= '0;
            fade_off_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SUPPRESS_SECS: suppress_secs_reg <= cfg_wr_data[SEC_W-1:0];
                REG_FADE_ON:       fade_on_reg       <= cfg_wr_data;
                REG_FADE_OFF:      fade_off_reg      <= cfg_wr_data;
                default:           ;
            endcase
        end
    end

    // Suppression window in milliseconds: seconds times 1000 as shifts and subtracts.
    logic [TIME_W-1:0] window_ms;
    assign window_ms = (TIME_W'(suppress_secs_reg) << 10) - (TIME_W'(suppress_secs_reg) << 4)
                     - (TIME_W'(suppress_secs_reg) << 3);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    ctl_state_t  state_reg, state_next;
    ctl_strobe_t strobe;
    logic        out_free;
    logic        in_fire;

    assign out_free = !m_valid || m_ready;
    assign in_fire  = s_valid && strobe.in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Strobes.
    always_comb begin
        strobe = '0;
        case (state_reg)
            ST_IDLE: begin
                strobe.in_ready = 1'b1;
                strobe.ram_rd   = s_valid;
            end
            ST_EXEC: begin
                strobe.commit = out_free;
            end
            default: ;
        endcase
    end

    assign s_ready = strobe.in_ready;

    // ------------------------------------------------------------------
    // Input beat capture
    // ------------------------------------------------------------------
    logic [FUNC_W-1:0]  func_reg;
    logic               ch_ok_reg;
    logic [AW-1:0]      ix_reg;
    logic [LEVEL_W-1:0] lvl_reg;
    logic [FADE_W-1:0]  fade_reg;
    logic               flag_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               s_ch_ok;
    logic [AW-1:0]      s_ix;

    assign s_ch_ok = (s_channel != '0) && (int'(s_channel) <= CHANNELS);
    assign s_ix    = AW'(s_channel - CH_W'(1));

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            func_reg  <= s_func;
            ch_ok_reg <= s_ch_ok;
            ix_reg    <= s_ix;
            lvl_reg   <= (s_level > LVL_MAX_C) ? LVL_MAX_C : s_level;
            fade_reg  <= s_fade_ms;
            flag_reg  <= s_flag_value;
            now_reg   <= s_now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Channel state memory with per-entry valid bits
    // ------------------------------------------------------------------
    chan_state_t          ram_rd_data;
    chan_state_t          cur;
    chan_state_t          nxt;
    logic [CHANNELS-1:0]  ch_valid_reg;
    logic                 ram_we;

    assign ram_we = strobe.commit && ch_ok_reg;

    dimctl_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ix_reg),
        .wr_data (nxt),
        .rd_en   (strobe.ram_rd),
        .rd_addr (s_ix),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_valid_reg <= '0;
        end else if (ram_we) begin
            ch_valid_reg[ix_reg] <= 1'b1;
        end
    end

    assign cur = ch_valid_reg[ix_reg] ? ram_rd_data : CHAN_RESET;

    // ------------------------------------------------------------------
    // Percent setpoint: round(level * 100 / LEVEL_MAX), at least one
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]  pct_num;
    logic [PROD_W-1:0] pct_prod;
    logic [PCT_W-1:0]  pct_q;
    logic [PCT_W-1:0]  pct_val;

    assign pct_num  = NUM_W'(32'(lvl_reg) * 32'd100) + HALF_MAX_C;
    assign pct_prod = PROD_W'(pct_num) * PROD_W'(RECIP);
    assign pct_q    = pct_prod[SHIFT +: PCT_W];
    assign pct_val  = (pct_q == '0) ? PCT_W'(1) : pct_q;

    // ------------------------------------------------------------------
    // Profile fade and suppression window
    // ------------------------------------------------------------------
    logic [FADE_W-1:0] fade_on_ch;
    logic [FADE_W-1:0] fade_off_ch;
    logic [FADE_W-1:0] prof_fade;
    logic [TIME_W-1:0] supp_diff;
    logic              win_open;
    logic [1:0]        tab_ix;

    assign tab_ix      = 2'(ix_reg);
    assign fade_on_ch  = fade_on_reg[tab_ix * FADE_W +: FADE_W];
    assign fade_off_ch = fade_off_reg[tab_ix * FADE_W +: FADE_W];
    assign prof_fade   = (cur.level == lvl_reg) ? '0 :
                         (lvl_reg > cur.level) ? fade_on_ch : fade_off_ch;

    assign supp_diff = cur.suppress_until - now_reg;
    assign win_open  = (cur.suppress_until != '0) && (supp_diff != '0) && !supp_diff[TIME_W-1];

    // ------------------------------------------------------------------
    // Read-modify-write of the channel word
    // ------------------------------------------------------------------
    logic               dv;
    logic [LEVEL_W-1:0] dl;
    logic [FADE_W-1:0]  df;
    logic               cur_on;

    assign cur_on = cur.level != '0;

    always_comb begin
        nxt = cur;
        dv  = 1'b0;
        dl  = '0;
        df  = '0;
        case (func_reg)
            FUNC_MANUAL_FADE, FUNC_MANUAL_PROF: begin
                nxt.auto_on = 1'b0;
                if (lvl_reg == '0) begin
                    // Manual off may remember the level and arm the auto-light window.
                    if (!cur.auto_on && cur_on && !cur.rocker_min) begin
                        nxt.last_level = cur.level;
                        nxt.has_last   = 1'b1;
                    end
                    if (cur_on && (suppress_secs_reg != '0)) begin
                        nxt.suppress_until = now_reg + window_ms;
                    end
                    nxt.rocker_min = 1'b0;
                    nxt.percent    = '0;
                end else begin
                    nxt.percent = pct_val;
                end
                nxt.level = lvl_reg;
                dv = 1'b1;
                dl = lvl_reg;
                df = (func_reg == FUNC_MANUAL_PROF) ? prof_fade : fade_reg;
            end
            FUNC_AUTO_LEVEL: begin
                if (lvl_reg == '0) begin
                    // Auto off clears the window and only turns off an automatic light.
                    nxt.suppress_until = '0;
                    if (cur.auto_on) begin
                        nxt.auto_on    = 1'b0;
                        nxt.rocker_min = 1'b0;
                        nxt.percent    = '0;
                        nxt.level      = '0;
                        dv = 1'b1;
                        df = prof_fade;
                    end
                end else if (!(cur_on && !cur.auto_on) && !(!cur.auto_on && win_open)) begin
                    nxt.auto_on    = 1'b1;
                    nxt.rocker_min = 1'b0;
                    nxt.percent    = pct_val;
                    nxt.level      = lvl_reg;
                    dv = 1'b1;
                    dl = lvl_reg;
                    df = prof_fade;
                end
            end
            FUNC_SET_ROCKER: begin
                nxt.rocker_min = flag_reg;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic               m_valid_reg;
    logic               drive_valid_reg;
    logic [LEVEL_W-1:0] drive_level_reg;
    logic [FADE_W-1:0]  drive_fade_reg;
    logic               accepted_reg;
    logic [LEVEL_W-1:0] level_now_reg;
    logic [PCT_W-1:0]   percent_now_reg;
    logic               auto_now_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (strobe.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (strobe.commit) begin
            drive_valid_reg <= ch_ok_reg && dv;
            drive_level_reg <= ch_ok_reg ? dl : '0;
            drive_fade_reg  <= ch_ok_reg ? df : '0;
            accepted_reg    <= ch_ok_reg;
            level_now_reg   <= ch_ok_reg ? nxt.level : '0;
            percent_now_reg <= (ch_ok_reg && (nxt.level != '0)) ? nxt.percent : '0;
            auto_now_reg    <= ch_ok_reg && nxt.auto_on;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_drive_valid   = drive_valid_reg;
    assign m_drive_level   = drive_level_reg;
    assign m_drive_fade_ms = drive_fade_reg;
    assign m_accepted      = accepted_reg;
    assign m_level_now     = level_now_reg;
    assign m_percent_now   = percent_now_reg;
    assign m_auto_now      = auto_now_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The state memory is written only in the compute cycle.
    a_we_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_EXEC))
        else $error("state memory written outside the compute cycle");

    // An accepted input beat is always followed by its compute cycle.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_EXEC))
        else $error("accepted beat not followed by compute cycle");

    // A rejected channel gives an all-zero result.
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_accepted) |-> (!m_drive_valid && (m_level_now == '0)
            && (m_percent_now == '0) && !m_auto_now))
        else $error("rejected channel produced a nonzero result");

    // The percent status is zero for a dark channel and never above full.
    a_percent_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_percent_now <= PCT_FULL)
            && ((m_level_now != '0) || (m_percent_now == '0))))
        else $error("percent status out of range");

endmodule

/* hw/rtl/dimctl_ram.sv */
module dimctl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port that holds between reads.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
